// File: sv/spid_pkg.sv
package spid_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic wb;
    logic fin;
  } spid_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_loop;
    logic more;
  } spid_stat_t;

endpackage

// File: sv/spid_ram.sv
module spid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/spid_ctrl.sv
module spid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spid_pkg::spid_stat_t stat,
  output spid_pkg::spid_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WBACK = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.go_loop ? S_READ : S_FINAL;
      end
      S_READ: begin
        state_nxt = S_WBACK;
      end
      S_WBACK: begin
        state_nxt = stat.more ? S_READ : S_FINAL;
      end
      S_FINAL: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.check = (state_r == S_CHECK);
  assign cmd.rd    = (state_r == S_READ);
  assign cmd.wb    = (state_r == S_WBACK);
  assign cmd.fin   = (state_r == S_FINAL);

endmodule

// File: sv/spid_dp.sv
module spid_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [spid_pkg::OP_W-1:0]             in_op,
  input  logic signed [spid_pkg::DATA_W-1:0]    in_value,
  input  logic [spid_pkg::CNT_W-1:0]            in_position,
  input  spid_pkg::spid_cmd_t                   cmd,
  output spid_pkg::spid_stat_t                  stat,
  output logic                                  out_valid,
  output logic signed [spid_pkg::DATA_W-1:0]    out_value_out,
  output logic [spid_pkg::CNT_W-1:0]            out_found_position,
  output logic [spid_pkg::CNT_W-1:0]            out_entry_count,
  output logic [spid_pkg::ST_W-1:0]             out_status
);

  localparam int AW = spid_pkg::ADDR_W;
  localparam int CW = spid_pkg::CNT_W;
  localparam int DW = spid_pkg::DATA_W;

  logic [spid_pkg::OP_W-1:0] op_r, op_nxt;
  logic [DW-1:0]             val_r, val_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             occ_r, occ_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [DW-1:0]             res_r, res_nxt;
  logic [CW-1:0]             found_r, found_nxt;
  logic [spid_pkg::ST_W-1:0] status_r, status_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [DW-1:0]             out_val_r, out_val_nxt;
  logic [CW-1:0]             out_found_r, out_found_nxt;
  logic [CW-1:0]             out_count_r, out_count_nxt;
  logic [spid_pkg::ST_W-1:0] out_status_r, out_status_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic                      full;
  logic                      empty;
  logic [CW-1:0]             eff_pos;
  logic [CW-1:0]             eff_pos_m1;
  logic [CW-1:0]             pos_m1;
  logic [CW-1:0]             idx_m1;
  logic [CW:0]               occ_p1;
  logic [spid_pkg::ST_W-1:0] chk_status;

  spid_ram #(
    .WIDTH (DW),
    .DEPTH (spid_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full       = (occ_r == CW'(spid_pkg::DEPTH));
  assign empty      = (occ_r == '0);
  // a pop is a delete of the top entry
  assign eff_pos    = (op_r == spid_pkg::OP_POP) ? occ_r : pos_r;
  assign eff_pos_m1 = eff_pos - 1'b1;
  assign pos_m1     = pos_r - 1'b1;
  assign idx_m1     = idx_r - 1'b1;
  assign occ_p1     = {1'b0, occ_r} + 1'b1;

  always_comb begin
    chk_status = spid_pkg::ST_OK;
    unique case (op_r)
      spid_pkg::OP_PUSH: begin
        if (full) chk_status = spid_pkg::ST_FULL;
      end
      spid_pkg::OP_POP: begin
        if (empty) chk_status = spid_pkg::ST_EMPTY;
      end
      spid_pkg::OP_INSERT: begin
        if (full) begin
          chk_status = spid_pkg::ST_FULL;
        end else if (pos_r == '0 || {1'b0, pos_r} > occ_p1) begin
          chk_status = spid_pkg::ST_RANGE;
        end
      end
      spid_pkg::OP_DELETE: begin
        if (empty) begin
          chk_status = spid_pkg::ST_EMPTY;
        end else if (pos_r == '0 || pos_r > occ_r) begin
          chk_status = spid_pkg::ST_RANGE;
        end
      end
      default: begin
        chk_status = spid_pkg::ST_OK;
      end
    endcase
  end

  // insert and search read one below the cursor, pop and delete read at it
  assign ram_raddr = (op_r == spid_pkg::OP_INSERT || op_r == spid_pkg::OP_SEARCH) ?
                     idx_m1[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    op_nxt         = op_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_val_nxt    = out_val_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    stat.go_loop   = 1'b0;
    stat.more      = 1'b0;

    if (chk_status == spid_pkg::ST_OK) begin
      unique case (op_r)
        spid_pkg::OP_POP, spid_pkg::OP_DELETE: stat.go_loop = 1'b1;
        spid_pkg::OP_INSERT: stat.go_loop = (occ_r != eff_pos_m1);
        spid_pkg::OP_SEARCH: stat.go_loop = !empty;
        default:             stat.go_loop = 1'b0;
      endcase
    end

    unique case (op_r)
      spid_pkg::OP_POP, spid_pkg::OP_DELETE: begin
        stat.more = ({1'b0, idx_r} + 1'b1) < {1'b0, occ_r};
      end
      spid_pkg::OP_INSERT: begin
        stat.more = (idx_r > pos_r);
      end
      spid_pkg::OP_SEARCH: begin
        stat.more = (ram_rdata != val_r) && (idx_r > CW'(1));
      end
      default: begin
        stat.more = 1'b0;
      end
    endcase

    if (cmd.load) begin
      op_nxt    = in_op;
      val_nxt   = in_value;
      pos_nxt   = in_position;
      res_nxt   = '0;
      found_nxt = '0;
    end

    if (cmd.check) begin
      status_nxt = chk_status;
      pos_nxt    = eff_pos;
      idx_nxt    = (op_r == spid_pkg::OP_POP || op_r == spid_pkg::OP_DELETE) ?
                   eff_pos_m1 : occ_r;
    end

    if (cmd.wb) begin
      unique case (op_r)
        spid_pkg::OP_POP, spid_pkg::OP_DELETE: begin
          // first read is the removed word, the rest slide down by one
          if (idx_r == pos_m1) begin
            res_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[AW-1:0];
            ram_wdata = ram_rdata;
          end
          idx_nxt = idx_r + 1'b1;
        end
        spid_pkg::OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[AW-1:0];
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
        end
        spid_pkg::OP_SEARCH: begin
          if (ram_rdata == val_r) begin
            found_nxt = idx_r;
          end else begin
            idx_nxt = idx_m1;
          end
        end
        default: begin
          idx_nxt = idx_r;
        end
      endcase
    end

    if (cmd.fin) begin
      if (status_r == spid_pkg::ST_OK) begin
        unique case (op_r)
          spid_pkg::OP_PUSH: begin
            ram_we    = 1'b1;
            ram_waddr = occ_r[AW-1:0];
            ram_wdata = val_r;
            occ_nxt   = occ_r + 1'b1;
          end
          spid_pkg::OP_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_r[AW-1:0];
            ram_wdata = val_r;
            occ_nxt   = occ_r + 1'b1;
          end
          spid_pkg::OP_POP, spid_pkg::OP_DELETE: begin
            occ_nxt = occ_r - 1'b1;
          end
          default: begin
            occ_nxt = occ_r;
          end
        endcase
      end
      out_valid_nxt  = 1'b1;
      out_val_nxt    = res_r;
      out_found_nxt  = found_r;
      out_count_nxt  = occ_nxt;
      out_status_nxt = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    res_r        <= res_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    out_val_r    <= out_val_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_value_out      = out_val_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;
  assign out_status         = out_status_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(spid_pkg::DEPTH))
    else $error("entry count above depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != spid_pkg::ST_OK |->
      out_val_r == '0 && out_found_r == '0)
    else $error("failed request returned data");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_found_r <= out_count_r)
    else $error("found position above entry count");

endmodule

// File: sv/stack_with_positional_insert_delete_unit.sv
// Bounded stack of 32-bit words with push, pop, positional insert and delete, and search.
// Request channel: drive in_op, in_value and in_position with start high; the request is
// taken at a rising edge where start is high and busy is low. busy stays high until the
// result has been produced.
// Result channel: out_valid is high for exactly one cycle with out_value_out,
// out_found_position, out_entry_count and out_status; the receiver cannot stall it.
// A request is checked, then takes a step per entry moved or compared in the storage RAM
// (a registered read, then one write or compare), then a final step. Push, failed requests
// and unknown codes skip the steps; pop reads one entry, delete and insert at position p
// step over the entries from p to the top, search walks down to its first hit.
// busy drops as out_valid rises, so the next request can be taken in the strobe cycle.
// Reset (rst_n low, synchronous) empties the stack and clears the strobe; stored words
// need no clearing since only entries below the count are ever read.
module stack_with_positional_insert_delete_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [spid_pkg::OP_W-1:0]          in_op,
  input  logic signed [spid_pkg::DATA_W-1:0] in_value,
  input  logic [spid_pkg::CNT_W-1:0]         in_position,
  output logic                               out_valid,
  output logic signed [spid_pkg::DATA_W-1:0] out_value_out,
  output logic [spid_pkg::CNT_W-1:0]         out_found_position,
  output logic [spid_pkg::CNT_W-1:0]         out_entry_count,
  output logic [spid_pkg::ST_W-1:0]          out_status
);

  spid_pkg::spid_cmd_t  cmd;
  spid_pkg::spid_stat_t stat;

  spid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spid_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_position        (in_position),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_value_out      (out_value_out),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_status         (out_status)
  );

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spid_pkg::*;

  // codes 5 to 7 carry no operation and leave the stack alone
  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
    logic                     drain;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] word;
    logic [CNT_W-1:0]         found;
    logic [CNT_W-1:0]         count;
    logic [ST_W-1:0]          status;
  } result_t;

  typedef struct packed {
    logic [DEPTH-1:0][DATA_W-1:0] words;
    logic [CNT_W-1:0]             fill;
  } stack_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_op = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [CNT_W-1:0] in_position = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_value_out;
  logic [CNT_W-1:0] out_found_position;
  logic [CNT_W-1:0] out_entry_count;
  logic [ST_W-1:0] out_status;

  request_t queued_requests[$];
  result_t due_results[$];
  stack_state_t gen_stack;
  stack_state_t model_stack;
  request_t next_req;
  request_t seen_req;
  result_t want;
  logic signed [DATA_W-1:0] value_pool[8];

  bit taken = 1'b0;
  int idle_left = 0;
  int total_requests = 0;
  int sent_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int mismatches = 0;
  int cycles = 0;
  int status_seen[4];
  int search_hits = 0;

  stack_with_positional_insert_delete_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_value_out      (out_value_out),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_status         (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one request to a stack image and returns the response it gives
  function automatic result_t stack_apply(input request_t req, inout stack_state_t s);
    int i;
    int n;
    int p;
    result_t res;
    res = '0;
    res.status = ST_OK;
    n = int'(s.fill);
    p = int'(req.position);
    case (req.op)
      OP_PUSH: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          s.words[n] = req.value;
          n++;
        end
      end
      OP_POP: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          n--;
          res.word = s.words[n];
        end
      end
      OP_INSERT: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > n + 1) begin
          res.status = ST_RANGE;
        end else begin
          for (i = DEPTH - 1; i > 0; i--)
            if (i >= p && i <= n) s.words[i] = s.words[i-1];
          s.words[p-1] = req.value;
          n++;
        end
      end
      OP_DELETE: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > n) begin
          res.status = ST_RANGE;
        end else begin
          res.word = s.words[p-1];
          for (i = p; i < n; i++) s.words[i-1] = s.words[i];
          n--;
        end
      end
      OP_SEARCH: begin
        // walk down from the top, keep the first hit
        for (i = n; i > 0; i--)
          if (res.found == 0 && s.words[i-1] == req.value) res.found = CNT_W'(i);
      end
      default: begin
      end
    endcase
    s.fill = CNT_W'(n);
    res.count = CNT_W'(n);
    return res;
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                             input int position, input bit drain = 1'b0);
    request_t req;
    req.op = op;
    req.value = value;
    req.position = CNT_W'(position);
    req.drain = drain;
    void'(stack_apply(req, gen_stack));
    queued_requests.push_back(req);
  endtask

  task automatic add_random_request(input bit filling, input bit drain);
    int pick;
    int hi;
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] value;
    int position;
    pick = $urandom_range(0, 99);
    if (filling) begin
      if (pick < 35) op = OP_PUSH;
      else if (pick < 55) op = OP_INSERT;
      else if (pick < 65) op = OP_POP;
      else if (pick < 75) op = OP_DELETE;
      else if (pick < 95) op = OP_SEARCH;
      else op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    end else begin
      if (pick < 10) op = OP_PUSH;
      else if (pick < 20) op = OP_INSERT;
      else if (pick < 50) op = OP_POP;
      else if (pick < 75) op = OP_DELETE;
      else if (pick < 95) op = OP_SEARCH;
      else op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    end
    // a small pool of values gives duplicates, so searches hit
    if ($urandom_range(0, 1) == 0) value = value_pool[$urandom_range(0, 7)];
    else value = $urandom;
    position = $urandom_range(0, 31);
    if ((op == OP_INSERT || op == OP_DELETE) && $urandom_range(0, 99) < 85) begin
      hi = (op == OP_INSERT) ? int'(gen_stack.fill) + 1 : int'(gen_stack.fill);
      if (hi < 1) hi = 1;
      position = $urandom_range(1, hi);
    end
    add_request(op, value, position, drain);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (queued_requests.size() == 0 ||
                   (queued_requests[0].drain && due_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_req = queued_requests.pop_front();
        in_op <= next_req.op;
        in_value <= next_req.value;
        in_position <= next_req.position;
        start <= 1'b1;
        sent_count++;
        if (sent_count < total_requests - 120 && (sent_count / 150) % 3 != 2 &&
            $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 12);
      end
    end
    taken = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // result first: a new request can be taken in the strobe cycle
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no request pending: value %0d found %0d count %0d status %0d",
                   $time, out_value_out, out_found_position, out_entry_count, out_status);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          checked_count++;
          if (out_value_out !== want.word) begin
            $display("%0t: value_out expected %0d actual %0d", $time, want.word, out_value_out);
            mismatches++;
          end
          if (out_found_position !== want.found) begin
            $display("%0t: found_position expected %0d actual %0d",
                     $time, want.found, out_found_position);
            mismatches++;
          end
          if (out_entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, out_entry_count);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        seen_req.op = in_op;
        seen_req.value = in_value;
        seen_req.position = in_position;
        seen_req.drain = 1'b0;
        want = stack_apply(seen_req, model_stack);
        status_seen[want.status]++;
        if (want.found != 0) search_hits++;
        due_results.push_back(want);
        accepted_count++;
        taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still unanswered",
               cycles, due_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'sh0000_0000;
    value_pool[1] = -32'sd1;
    value_pool[2] = 32'sh7FFF_FFFF;
    value_pool[3] = 32'sh8000_0000;
    value_pool[4] = 32'sd1;
    value_pool[5] = 32'sh5555_5555;
    value_pool[6] = 32'shAAAA_AAAA;
    value_pool[7] = 32'sd42;
    gen_stack = '0;
    model_stack = '0;
    for (int k = 0; k < 4; k++) status_seen[k] = 0;

    // empty-stack cases, empty check ahead of the position check
    add_request(OP_POP, 32'sd7, 0);
    add_request(OP_DELETE, 32'sd0, 0);
    add_request(OP_SEARCH, 32'sd0, 0);
    add_request(OP_INSERT, 32'sd9, 2);
    // insert one past the top acts as a push
    add_request(OP_INSERT, 32'sh7FFF_FFFF, 1);
    add_request(OP_INSERT, 32'sd9, 0);
    add_request(OP_PUSH, 32'sh8000_0000, 0);
    add_request(OP_INSERT, -32'sd1, 2);
    add_request(OP_SEARCH, -32'sd1, 31);
    add_request(OP_DELETE, 32'sd0, 4);
    add_request(OP_DELETE, 32'sd0, 1);
    add_request(OP_RESERVED_HI, 32'shFFFF_FFFF, 31);
    for (int k = 0; k < 14; k++) add_request(OP_PUSH, k * 32'sh1111_1111, k);
    // full: overflow wins over a bad position
    add_request(OP_PUSH, 32'sd3, 0);
    add_request(OP_INSERT, 32'sd3, 0);
    add_request(OP_SEARCH, 32'sh8000_0000, 0);

    for (int k = 0; k < RANDOM_REQUESTS; k++)
      add_random_request((k / 64) % 2 == 0, k % 250 == 0);
    total_requests = queued_requests.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (accepted_count < total_requests) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests checked; %0d overflow, %0d underflow, %0d bad position, %0d search hits",
             checked_count, status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], search_hits);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
